[rtl/fpct_pkg.sv]
// ----------------------------------------------------------------------------
// fpct_pkg: shared types and constants of the flow pair counter table
// widths of the record and result words, table depths and status codes
// ----------------------------------------------------------------------------
`default_nettype none
package fpct_pkg;
   localparam int MAC_TABLE_DEPTH = 64;
   localparam int IP_TABLE_DEPTH  = 64;
   localparam int MAC_KEY_W = 96;
   localparam int IP_KEY_W  = 64;
   localparam int CNT_W     = 32;
   localparam int INC_W     = 8;
   localparam int IDX_W     = 6;
   localparam int MAC_CNT_W = $clog2(MAC_TABLE_DEPTH + 1);
   localparam int IP_CNT_W  = $clog2(IP_TABLE_DEPTH + 1);
   // both chains hold as many cells as the deeper table
   localparam int CHAIN_DEPTH = (MAC_TABLE_DEPTH > IP_TABLE_DEPTH) ?
                                MAC_TABLE_DEPTH : IP_TABLE_DEPTH;
   localparam int SCAN_W    = $clog2(CHAIN_DEPTH + 1);

   localparam logic [1:0] MAC_MATCH  = 2'd0;
   localparam logic [1:0] MAC_INSERT = 2'd1;
   localparam logic [1:0] MAC_DROP   = 2'd2;
   localparam logic [1:0] IP_NONE    = 2'd0;
   localparam logic [1:0] IP_MATCH   = 2'd1;
   localparam logic [1:0] IP_INSERT  = 2'd2;
   localparam logic [1:0] IP_DROP    = 2'd3;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   typedef struct packed {
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [7:0]  packet_increment;
      logic        has_ip;
      logic [31:0] src_ip;
      logic [31:0] ip_dest;
      logic [7:0]  tcp_increment;
      logic [7:0]  udp_increment;
   } req_type;

   typedef struct packed {
      logic [1:0]  mac_status;
      logic [5:0]  mac_index;
      logic [31:0] mac_packets;
      logic [1:0]  ip_status;
      logic [5:0]  ip_index;
      logic [31:0] tcp_total;
      logic [31:0] udp_total;
   } rsp_type;

   // search control word broadcast to a chain
   typedef struct packed {
      logic start;  // clear hit flag and scan position
      logic shift;  // advance the ring one place
      logic insert; // write the key and increments into the first free cell
   } chain_ctl_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [INC_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {{(CNT_W-INC_W+1){1'b0}}, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction
endpackage
`default_nettype wire

[rtl/fpct_if.sv]
// ----------------------------------------------------------------------------
// fpct_if: valid/ready channel
// carries one payload word per handshake
// ----------------------------------------------------------------------------
`default_nettype none
interface fpct_req_if;
   logic valid;
   logic ready;
   fpct_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface fpct_rsp_if;
   logic valid;
   logic ready;
   fpct_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/flow_pair_counter_table.sv]
// a new record is taken only once the last one has been scanned and its
//   result word built, since the entry chains rotate past the single
//   compare stage at their head
// both tables scan in parallel over chains as deep as the deeper table
// a result word still waiting at the output holds the next record in its
//   append cycle; otherwise the output register hides sink stalls
// reset: synchronous, active high; both tables read as empty afterwards
// ----------------------------------------------------------------------------
// flow_pair_counter_table: MAC pair and IP pair counter tables
// two rings of cells searched by rotation, appended on a miss
// ----------------------------------------------------------------------------
`default_nettype none
module flow_pair_counter_table (
   input wire logic clock,
   input wire logic reset,
   fpct_req_if.sink   req,
   fpct_rsp_if.source rsp
);
   import fpct_pkg::*;

   state_type state_ff, state_in;
   req_type rec_ff;
   rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;
   logic [SCAN_W-1:0] cnt_ff, cnt_in;
   chain_ctl_type mctl, ictl;
   logic mhit, ihit;
   logic [SCAN_W-1:0] mpos, mused;
   logic [SCAN_W-1:0] ipos, iused;
   logic [CNT_W-1:0] mtot, mdummy, ttot, utot;
   logic [MAC_KEY_W-1:0] ikey;

   assign ikey = {{(MAC_KEY_W-IP_KEY_W){1'b0}}, rec_ff.src_ip, rec_ff.ip_dest};

   fpct_chain u_mac (
      .clock(clock), .reset(reset), .ctl(mctl),
      .key({rec_ff.src_mac, rec_ff.dst_mac}),
      .inc_a(rec_ff.packet_increment), .inc_b('0),
      .hit(mhit), .hit_pos(mpos), .used(mused), .tot_a(mtot), .tot_b(mdummy));

   fpct_chain u_ip (
      .clock(clock), .reset(reset), .ctl(ictl), .key(ikey),
      .inc_a(rec_ff.tcp_increment), .inc_b(rec_ff.udp_increment),
      .hit(ihit), .hit_pos(ipos), .used(iused), .tot_a(ttot), .tot_b(utot));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff <= cnt_in;
      out_ff <= out_in;
      if (req.valid && req.ready) begin
         rec_ff <= req.data;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      out_in = out_ff;
      // result word leaves when the sink takes it
      out_valid_in = out_valid_ff && !rsp.ready;
      mctl = '0;
      ictl = '0;
      req.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // take the next record
            req.ready = 1'b1;
            if (req.valid) begin
               state_in = ST_SCAN;
               cnt_in = '0;
            end
         end
         ST_SCAN: begin
            // first scan cycle clears hit flags, then one rotation per cycle
            if (cnt_ff == '0) begin
               mctl.start = 1'b1;
               ictl.start = rec_ff.has_ip;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               mctl.shift = 1'b1;
               ictl.shift = rec_ff.has_ip;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == SCAN_W'(CHAIN_DEPTH)) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // append on a miss while the table has room, else drop, and build the result word once the output is free
            if (!out_valid_ff || rsp.ready) begin
               out_in = '0;
               if (mhit) begin
                  out_in.mac_status = MAC_MATCH;
                  out_in.mac_index = IDX_W'(mpos);
                  out_in.mac_packets = mtot;
               end else if (mused < SCAN_W'(MAC_TABLE_DEPTH)) begin
                  mctl.insert = 1'b1;
                  out_in.mac_status = MAC_INSERT;
                  out_in.mac_index = IDX_W'(mused);
                  out_in.mac_packets = {{(CNT_W-INC_W){1'b0}}, rec_ff.packet_increment};
               end else begin
                  out_in.mac_status = MAC_DROP;
               end
               if (!rec_ff.has_ip) begin
                  out_in.ip_status = IP_NONE;
               end else if (ihit) begin
                  out_in.ip_status = IP_MATCH;
                  out_in.ip_index = IDX_W'(ipos);
                  out_in.tcp_total = ttot;
                  out_in.udp_total = utot;
               end else if (iused < SCAN_W'(IP_TABLE_DEPTH)) begin
                  ictl.insert = 1'b1;
                  out_in.ip_status = IP_INSERT;
                  out_in.ip_index = IDX_W'(iused);
                  out_in.tcp_total = {{(CNT_W-INC_W){1'b0}}, rec_ff.tcp_increment};
                  out_in.udp_total = {{(CNT_W-INC_W){1'b0}}, rec_ff.udp_increment};
               end else begin
                  out_in.ip_status = IP_DROP;
               end
               out_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.data = out_ff;
endmodule
`default_nettype wire

[rtl/fpct_cell.sv]
// ----------------------------------------------------------------------------
// fpct_cell: one table entry of a chain
// holds a key and two counters; while shift is high, entries rotate one place
// a cycle so the head cell sees every entry in turn
// ----------------------------------------------------------------------------
`default_nettype none
module fpct_cell (
   input  wire logic                         clock,
   input  wire logic                         shift,
   input  wire logic                         load,       // take data from outside
   input  wire logic [fpct_pkg::MAC_KEY_W-1:0] key_in,
   input  wire logic [fpct_pkg::CNT_W-1:0]     cnt_a_in,
   input  wire logic [fpct_pkg::CNT_W-1:0]     cnt_b_in,
   output logic      [fpct_pkg::MAC_KEY_W-1:0] key_out,
   output logic      [fpct_pkg::CNT_W-1:0]     cnt_a_out,
   output logic      [fpct_pkg::CNT_W-1:0]     cnt_b_out
);
   import fpct_pkg::*;
   logic [MAC_KEY_W-1:0] key_ff;
   logic [CNT_W-1:0] a_ff, b_ff;

   always_ff @(posedge clock) begin
      if (shift || load) begin
         key_ff <= key_in;
         a_ff   <= cnt_a_in;
         b_ff   <= cnt_b_in;
      end
   end
   assign key_out   = key_ff;
   assign cnt_a_out = a_ff;
   assign cnt_b_out = b_ff;
endmodule
`default_nettype wire

[rtl/fpct_chain.sv]
// ----------------------------------------------------------------------------
// fpct_chain: ring of table cells with a compare and update stage at the head
// each cycle that shift is high, the head entry is compared with the key, updated on a hit, and
// passed to the tail; after depth shifts the ring is back in place
// ----------------------------------------------------------------------------
`default_nettype none
module fpct_chain (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fpct_pkg::chain_ctl_type         ctl,
   input  wire logic [fpct_pkg::MAC_KEY_W-1:0] key,
   input  wire logic [fpct_pkg::INC_W-1:0]     inc_a,
   input  wire logic [fpct_pkg::INC_W-1:0]     inc_b,
   output logic                                hit,
   output logic [fpct_pkg::SCAN_W-1:0]         hit_pos,
   output logic [fpct_pkg::SCAN_W-1:0]         used,
   output logic [fpct_pkg::CNT_W-1:0]          tot_a,
   output logic [fpct_pkg::CNT_W-1:0]          tot_b
);
   import fpct_pkg::*;
   logic [MAC_KEY_W-1:0] k [CHAIN_DEPTH];
   logic [CNT_W-1:0] a [CHAIN_DEPTH], b [CHAIN_DEPTH];
   logic [SCAN_W-1:0] used_ff, pos_ff, hpos_ff;
   logic hit_ff;
   logic [CNT_W-1:0] ta_ff, tb_ff;
   logic head_hit;
   logic [CNT_W-1:0] na, nb;

   // head is entry 0 of the ring at scan start; pos counts shifts done
   assign head_hit = (pos_ff < used_ff) && !hit_ff && (k[0] == key);
   assign na = head_hit ? sat_add(a[0], inc_a) : a[0];
   assign nb = head_hit ? sat_add(b[0], inc_b) : b[0];

   for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
      logic [MAC_KEY_W-1:0] kin;
      logic [CNT_W-1:0] ain, bin;
      logic ld;
      if (g == CHAIN_DEPTH-1) begin : g_tail
         assign kin = k[0];
         assign ain = na;
         assign bin = nb;
      end else begin : g_mid
         assign kin = (ctl.insert) ? key : k[g+1];
         assign ain = (ctl.insert) ? {{(CNT_W-INC_W){1'b0}}, inc_a} : a[g+1];
         assign bin = (ctl.insert) ? {{(CNT_W-INC_W){1'b0}}, inc_b} : b[g+1];
      end
      assign ld = ctl.insert && (used_ff == SCAN_W'(g));
      fpct_cell u_cell (
         .clock(clock), .shift(ctl.shift), .load(ld),
         .key_in((g == CHAIN_DEPTH-1 && ctl.insert) ? key : kin),
         .cnt_a_in((g == CHAIN_DEPTH-1 && ctl.insert) ?
                   {{(CNT_W-INC_W){1'b0}}, inc_a} : ain),
         .cnt_b_in((g == CHAIN_DEPTH-1 && ctl.insert) ?
                   {{(CNT_W-INC_W){1'b0}}, inc_b} : bin),
         .key_out(k[g]), .cnt_a_out(a[g]), .cnt_b_out(b[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         hit_ff  <= 1'b0;
         pos_ff  <= '0;
      end else if (ctl.start) begin
         hit_ff <= 1'b0;
         pos_ff <= '0;
      end else if (ctl.shift) begin
         pos_ff <= pos_ff + 1'b1;
         if (head_hit) begin
            hit_ff  <= 1'b1;
            hpos_ff <= pos_ff;
            ta_ff   <= na;
            tb_ff   <= nb;
         end
      end else if (ctl.insert) begin
         used_ff <= used_ff + 1'b1;
      end
   end

   assign hit = hit_ff;
   assign hit_pos = hpos_ff;
   assign used = used_ff;
   assign tot_a = ta_ff;
   assign tot_b = tb_ff;
endmodule
`default_nettype wire

[rtl/fpct_checker.sv]
// ----------------------------------------------------------------------------
// fpct_checker: port level checks of the flow pair counter table
// ----------------------------------------------------------------------------
`default_nettype none
module fpct_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_mac_status,
   input wire logic [1:0] rsp_ip_status,
   input wire logic [5:0] rsp_ip_index,
   input wire logic [31:0] rsp_mac_packets
);
   import fpct_pkg::*;
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready during scan");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mac_status) &&
      $stable(rsp_ip_status) && $stable(rsp_ip_index) && $stable(rsp_mac_packets)))
      else $error("result word changed while waiting");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_mac_status <= MAC_DROP) else $error("bad mac status");
   a_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mac_status == MAC_DROP) |-> rsp_mac_packets == '0)
      else $error("dropped pair with count");
   a_noip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ip_status == IP_NONE) |-> rsp_ip_index == '0)
      else $error("ip index without ip");
endmodule

bind flow_pair_counter_table fpct_checker u_fpct_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_mac_status(rsp.data.mac_status), .rsp_ip_status(rsp.data.ip_status),
   .rsp_ip_index(rsp.data.ip_index), .rsp_mac_packets(rsp.data.mac_packets));
`default_nettype wire
